// ===== rtl/rxu_pkg.sv =====
// ----------------------------------------------------------------------------
// rxu_pkg
// Shared types, opcodes and default sizes for the integer execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rxu_pkg;

    localparam int unsigned RXU_DATA_WORDS    = 2048;
    localparam int unsigned RXU_REG_COUNT     = 32;
    localparam int unsigned RXU_PROGRAM_WORDS = 1024;
    localparam int unsigned RXU_QUEUE_DEPTH   = 2;

    localparam logic [3:0] CMD_ADD   = 4'd0;
    localparam logic [3:0] CMD_SUB   = 4'd1;
    localparam logic [3:0] CMD_MUL   = 4'd2;
    localparam logic [3:0] CMD_MOVI  = 4'd3;
    localparam logic [3:0] CMD_JEQ   = 4'd4;
    localparam logic [3:0] CMD_AND   = 4'd5;
    localparam logic [3:0] CMD_XORI  = 4'd6;
    localparam logic [3:0] CMD_JMP   = 4'd7;
    localparam logic [3:0] CMD_LSL   = 4'd8;
    localparam logic [3:0] CMD_LSR   = 4'd9;
    localparam logic [3:0] CMD_LOAD  = 4'd10;
    localparam logic [3:0] CMD_STORE = 4'd11;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [4:0]         first_reg;
        logic [4:0]         second_reg;
        logic [4:0]         third_reg;
        logic signed [15:0] immediate;
        logic [9:0]         jump_target;
    } rxu_in_t;

    typedef struct packed {
        logic [9:0]         next_pc;
        logic               reg_written;
        logic [4:0]         reg_index;
        logic signed [31:0] reg_value;
        logic               mem_written;
        logic [10:0]        mem_address;
        logic               mem_fault;
    } rxu_out_t;

    typedef enum logic [2:0] {
        ALU_NONE = 3'd0,
        ALU_ADD  = 3'd1,
        ALU_SUB  = 3'd2,
        ALU_AND  = 3'd3,
        ALU_XOR  = 3'd4,
        ALU_IMM  = 3'd5,
        ALU_SHL  = 3'd6,
        ALU_SHR  = 3'd7
    } rxu_alu_t;

    // decoded instruction handed from front to back
    typedef struct packed {
        rxu_alu_t    alu;
        logic        wr_reg;
        logic        is_mul;
        logic        is_load;
        logic        is_store;
        logic        is_jeq;
        logic        is_jmp;
        logic [4:0]  rd;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic        rd_ok;
        logic        rs_ok;
        logic        rt_ok;
        logic [31:0] imm;
        logic [4:0]  shamt;
        logic [9:0]  target;
    } rxu_uop_t;

    // back-end status seen by the front
    typedef struct packed {
        logic pop;
        logic clearing;
    } rxu_bstat_t;

endpackage

`default_nettype wire

// ===== rtl/rxu_front.sv =====
// ----------------------------------------------------------------------------
// rxu_front
// Accepts requests, decodes them into micro-ops and buffers them in a
// small queue ahead of the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rxu_front import rxu_pkg::*; #(
    parameter int unsigned REG_COUNT = RXU_REG_COUNT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire rxu_in_t    s_data,
    input  wire rxu_bstat_t bstat,
    output logic            q_valid,
    output rxu_uop_t        q_uop
);

    localparam int unsigned PTR_W = $clog2(RXU_QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(RXU_QUEUE_DEPTH + 1);

    rxu_uop_t             dec;
    rxu_uop_t             entry_reg [RXU_QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 push;

    always_comb begin
        dec          = '0;
        dec.alu      = ALU_NONE;
        dec.rd       = s_data.first_reg;
        dec.rs       = s_data.second_reg;
        dec.rt       = s_data.third_reg;
        dec.rd_ok    = (s_data.first_reg != 5'd0) &&
                       ({1'b0, s_data.first_reg} < 6'(REG_COUNT));
        dec.rs_ok    = (s_data.second_reg != 5'd0) &&
                       ({1'b0, s_data.second_reg} < 6'(REG_COUNT));
        dec.rt_ok    = (s_data.third_reg != 5'd0) &&
                       ({1'b0, s_data.third_reg} < 6'(REG_COUNT));
        dec.imm      = {{16{s_data.immediate[15]}}, s_data.immediate};
        dec.shamt    = s_data.immediate[4:0];
        dec.target   = s_data.jump_target;
        case (s_data.cmd)
            CMD_ADD: begin
                dec.alu = ALU_ADD;
                dec.wr_reg = 1'b1;
            end
            CMD_SUB: begin
                dec.alu = ALU_SUB;
                dec.wr_reg = 1'b1;
            end
            CMD_MUL:   dec.is_mul = 1'b1;
            CMD_MOVI: begin
                dec.alu = ALU_IMM;
                dec.wr_reg = 1'b1;
            end
            CMD_JEQ:   dec.is_jeq = 1'b1;
            CMD_AND: begin
                dec.alu = ALU_AND;
                dec.wr_reg = 1'b1;
            end
            CMD_XORI: begin
                dec.alu = ALU_XOR;
                dec.wr_reg = 1'b1;
            end
            CMD_JMP:   dec.is_jmp = 1'b1;
            CMD_LSL: begin
                dec.alu = ALU_SHL;
                dec.wr_reg = 1'b1;
            end
            CMD_LSR: begin
                dec.alu = ALU_SHR;
                dec.wr_reg = 1'b1;
            end
            CMD_LOAD:  dec.is_load = 1'b1;
            CMD_STORE: dec.is_store = 1'b1;
            default: begin
            end
        endcase
    end

    assign s_ready = (cnt_reg != CNT_W'(RXU_QUEUE_DEPTH)) && !bstat.clearing;
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_uop   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(RXU_QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (bstat.pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(RXU_QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !bstat.pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && bstat.pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

    ap_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= 32'(RXU_QUEUE_DEPTH))
        else $error("queue count overflow");

    ap_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        bstat.pop |-> q_valid)
        else $error("pop from empty queue");

    ap_cnt_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !bstat.pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// ===== rtl/rxu_back.sv =====
// ----------------------------------------------------------------------------
// rxu_back
// Execute sequencer: register file, data memory, program counter,
// modulo unit for branch targets and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rxu_back import rxu_pkg::*; #(
    parameter int unsigned DATA_WORDS    = RXU_DATA_WORDS,
    parameter int unsigned REG_COUNT     = RXU_REG_COUNT,
    parameter int unsigned PROGRAM_WORDS = RXU_PROGRAM_WORDS
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     q_valid,
    input  wire rxu_uop_t q_uop,
    output rxu_bstat_t    bstat,
    output logic          m_valid,
    input  wire logic     m_ready,
    output rxu_out_t      m_data
);

    localparam int unsigned AW    = $clog2(DATA_WORDS);
    localparam int unsigned RW    = $clog2(REG_COUNT);
    localparam int unsigned PW    = $clog2(PROGRAM_WORDS);
    localparam int unsigned KOFS  = ((32768 + PROGRAM_WORDS - 1) / PROGRAM_WORDS)
                                    * PROGRAM_WORDS;
    localparam int unsigned TMAX  = 2 * PROGRAM_WORDS + 65535;
    localparam int unsigned TW    = $clog2(TMAX + 1);
    localparam int unsigned SH    = TW + $clog2(PROGRAM_WORDS);
    localparam int unsigned MW    = TW + 2;
    localparam int unsigned PRW   = TW + MW;
    localparam logic [63:0] MDIV  = ((64'd1 << SH) + 64'(PROGRAM_WORDS) - 64'd1)
                                    / 64'(PROGRAM_WORDS);
    localparam logic [MW-1:0] MDIV_W = MDIV[MW-1:0];

    typedef enum logic [3:0] {
        ST_ISSUE = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_MOD   = 4'b0100,
        ST_FIN   = 4'b1000
    } rxu_state_t;

    rxu_state_t        state_reg, state_next;
    rxu_uop_t          cur_reg;

    logic [31:0]       rf_ab [REG_COUNT];
    logic [31:0]       rf_c  [REG_COUNT];
    logic [REG_COUNT-1:0] rf_vld_reg;
    logic [31:0]       ra_reg, rb_reg, rc_reg;
    logic              ra_vld_reg, rb_vld_reg, rc_vld_reg;
    logic              wb_vld_reg;
    logic [4:0]        wb_idx_reg;
    logic [31:0]       wb_val_reg;

    logic [31:0]       dmem [DATA_WORDS];
    logic [31:0]       dmem_q_reg;
    logic              clr_busy_reg;
    logic [AW-1:0]     clr_cnt_reg;

    logic [PW-1:0]     pc_reg;
    logic [PW-1:0]     pc_inc_reg;
    logic [31:0]       mul_reg;
    logic [TW-1:0]     t_reg;
    logic [PRW-1:0]    prod_reg;
    logic [10:0]       maddr_reg;

    logic              m_valid_reg;
    rxu_out_t          m_data_reg;

    logic [31:0]       a_op, b_op, c_op, alu_val, tsum, value;
    logic signed [32:0] addr_s;
    logic              fault, eq, mem_op, quick, out_free, done, pop, wr;
    logic [AW-1:0]     mem_idx;
    logic [PW-1:0]     pc_inc, npc, npc_mod;
    logic [PRW-SH-1:0] quo;
    logic [TW-1:0]     rem;
    logic [RW-1:0]     rs_i, rt_i, rd_i;
    logic              dm_we;
    logic [AW-1:0]     dm_waddr;
    logic [31:0]       dm_wdata;
    rxu_out_t          res;

    // operands with forwarding of the most recent register write
    always_comb begin
        if (!cur_reg.rs_ok) begin
            a_op = '0;
        end else if (wb_vld_reg && wb_idx_reg == cur_reg.rs) begin
            a_op = wb_val_reg;
        end else begin
            a_op = ra_vld_reg ? ra_reg : '0;
        end
        if (!cur_reg.rt_ok) begin
            b_op = '0;
        end else if (wb_vld_reg && wb_idx_reg == cur_reg.rt) begin
            b_op = wb_val_reg;
        end else begin
            b_op = rb_vld_reg ? rb_reg : '0;
        end
        if (!cur_reg.rd_ok) begin
            c_op = '0;
        end else if (wb_vld_reg && wb_idx_reg == cur_reg.rd) begin
            c_op = wb_val_reg;
        end else begin
            c_op = rc_vld_reg ? rc_reg : '0;
        end
    end

    always_comb begin
        case (cur_reg.alu)
            ALU_ADD:  alu_val = a_op + b_op;
            ALU_SUB:  alu_val = a_op - b_op;
            ALU_AND:  alu_val = a_op & b_op;
            ALU_XOR:  alu_val = a_op ^ cur_reg.imm;
            ALU_IMM:  alu_val = cur_reg.imm;
            ALU_SHL:  alu_val = a_op << cur_reg.shamt;
            ALU_SHR:  alu_val = a_op >> cur_reg.shamt;
            default:  alu_val = '0;
        endcase
    end

    always_comb begin
        addr_s  = $signed({a_op[31], a_op}) + $signed({cur_reg.imm[31], cur_reg.imm});
        fault   = addr_s[32] || (addr_s[31:0] >= 32'(DATA_WORDS));
        mem_idx = addr_s[AW-1:0];
        eq      = (c_op == a_op);
        mem_op  = cur_reg.is_load || cur_reg.is_store;
        pc_inc  = (pc_reg == PW'(PROGRAM_WORDS - 1)) ? '0 : pc_reg + PW'(1);
        if (cur_reg.is_jmp) begin
            tsum = 32'(cur_reg.target) + 32'(KOFS);
        end else begin
            tsum = 32'(pc_reg) + 32'd1 + cur_reg.imm + 32'(KOFS);
        end
        quo     = prod_reg[PRW-1:SH];
        rem     = t_reg - TW'(quo * PROGRAM_WORDS);
        npc_mod = rem[PW-1:0];
        quick   = !(cur_reg.is_mul || (cur_reg.is_load && !fault) || cur_reg.is_jmp ||
                    (cur_reg.is_jeq && eq));
        out_free = !m_valid_reg || m_ready;
        done     = out_free && (((state_reg == ST_EXEC) && quick) || (state_reg == ST_FIN));
        pop      = q_valid && ((state_reg == ST_ISSUE) || done);
    end

    always_comb begin
        res = '0;
        if (state_reg == ST_FIN) begin
            npc   = (cur_reg.is_jmp || cur_reg.is_jeq) ? npc_mod : pc_inc_reg;
            wr    = cur_reg.rd_ok && (cur_reg.is_mul || cur_reg.is_load);
            value = cur_reg.is_load ? dmem_q_reg : mul_reg;
            res.mem_address = cur_reg.is_load ? maddr_reg : '0;
        end else begin
            npc   = pc_inc;
            wr    = cur_reg.wr_reg && cur_reg.rd_ok;
            value = alu_val;
            res.mem_written = cur_reg.is_store && !fault;
            res.mem_address = (mem_op && !fault) ? 11'(mem_idx) : '0;
            res.mem_fault   = mem_op && fault;
        end
        res.next_pc     = 10'(npc);
        res.reg_written = wr;
        res.reg_index   = wr ? cur_reg.rd : '0;
        res.reg_value   = wr ? value : '0;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ISSUE: begin
                if (pop) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (pop) begin
                    state_next = ST_EXEC;
                end else if (done) begin
                    state_next = ST_ISSUE;
                end else if (!quick) begin
                    state_next = (cur_reg.is_jmp || cur_reg.is_jeq) ? ST_MOD : ST_FIN;
                end
            end
            ST_MOD: state_next = ST_FIN;
            ST_FIN: begin
                if (pop) begin
                    state_next = ST_EXEC;
                end else if (done) begin
                    state_next = ST_ISSUE;
                end
            end
            default: state_next = ST_ISSUE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_ISSUE;
            pc_reg       <= '0;
            m_valid_reg  <= 1'b0;
            wb_vld_reg   <= 1'b0;
            rf_vld_reg   <= '0;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (done) begin
                pc_reg      <= npc;
                m_valid_reg <= 1'b1;
                wb_vld_reg  <= wr;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (done && wr) begin
                rf_vld_reg[rd_i] <= 1'b1;
            end
            if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DATA_WORDS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rs_i = q_uop.rs_ok ? q_uop.rs[RW-1:0] : '0;
    assign rt_i = q_uop.rt_ok ? q_uop.rt[RW-1:0] : '0;
    assign rd_i = cur_reg.rd[RW-1:0];

    // register file: two copies share the write, three read ports
    always_ff @(posedge aclk) begin
        if (done && wr) begin
            rf_ab[rd_i] <= value;
        end
        if (pop) begin
            ra_reg <= rf_ab[rs_i];
            rb_reg <= rf_ab[rt_i];
        end
    end

    always_ff @(posedge aclk) begin
        if (done && wr) begin
            rf_c[rd_i] <= value;
        end
        if (pop) begin
            rc_reg <= rf_c[q_uop.rd_ok ? q_uop.rd[RW-1:0] : '0];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg    <= q_uop;
            ra_vld_reg <= rf_vld_reg[rs_i];
            rb_vld_reg <= rf_vld_reg[rt_i];
            rc_vld_reg <= rf_vld_reg[q_uop.rd_ok ? q_uop.rd[RW-1:0] : '0];
        end
        if (done) begin
            wb_idx_reg <= cur_reg.rd;
            wb_val_reg <= value;
            m_data_reg <= res;
        end
        if (state_reg == ST_EXEC) begin
            mul_reg    <= a_op * b_op;
            t_reg      <= tsum[TW-1:0];
            pc_inc_reg <= pc_inc;
            maddr_reg  <= 11'(mem_idx);
        end
        if (state_reg == ST_MOD) begin
            prod_reg <= t_reg * MDIV_W;
        end
    end

    assign dm_we    = clr_busy_reg ||
                      ((state_reg == ST_EXEC) && done && cur_reg.is_store && !fault);
    assign dm_waddr = clr_busy_reg ? clr_cnt_reg : mem_idx;
    assign dm_wdata = clr_busy_reg ? '0 : c_op;

    always_ff @(posedge aclk) begin
        if (dm_we) begin
            dmem[dm_waddr] <= dm_wdata;
        end
        if ((state_reg == ST_EXEC) && cur_reg.is_load) begin
            dmem_q_reg <= dmem[mem_idx];
        end
    end

    assign bstat.pop      = pop;
    assign bstat.clearing = clr_busy_reg;
    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;

    ap_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !pop)
        else $error("request issued during memory clear");

    ap_mod_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MOD |=> state_reg == ST_FIN)
        else $error("modulo step did not finish");

    ap_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> 32'(npc) < 32'(PROGRAM_WORDS))
        else $error("next pc out of range");

    ap_no_r0: assert property (@(posedge aclk) disable iff (!aresetn)
        done && res.reg_written |-> res.reg_index != 5'd0)
        else $error("write to register zero");

    ap_mem_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !(res.mem_written && res.mem_fault))
        else $error("faulting store reported as written");

endmodule

`default_nettype wire

// ===== rtl/risc_execute_unit.sv =====
// ----------------------------------------------------------------------------
// risc_execute_unit
// Integer execute unit: decode front, request queue and execute back end.
// ----------------------------------------------------------------------------
// Flow: ALU ops, jumps not taken, stores and faulting loads finish in
//   ST_EXEC; mul and loads go on to ST_FIN, jmp and taken jeq via ST_MOD to ST_FIN.
// Throughput: 1 request/cycle for ops finishing in ST_EXEC while the output
//   is not stalled; mul, load, jmp and taken jeq hold the execute stage longer (ST_MOD runs the modulo unit on the pc).
// Reset: after aresetn the data memory is cleared one word per cycle,
//   all DATA_WORDS words (2048 by default), with s_ready held low meanwhile.
`default_nettype none

module risc_execute_unit import rxu_pkg::*; #(
    parameter int unsigned DATA_WORDS    = RXU_DATA_WORDS,
    parameter int unsigned REG_COUNT     = RXU_REG_COUNT,
    parameter int unsigned PROGRAM_WORDS = RXU_PROGRAM_WORDS
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire rxu_in_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output rxu_out_t     m_data
);

    rxu_bstat_t bstat;
    logic       q_valid;
    rxu_uop_t   q_uop;

    rxu_front #(
        .REG_COUNT (REG_COUNT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .bstat   (bstat),
        .q_valid (q_valid),
        .q_uop   (q_uop)
    );

    rxu_back #(
        .DATA_WORDS    (DATA_WORDS),
        .REG_COUNT     (REG_COUNT),
        .PROGRAM_WORDS (PROGRAM_WORDS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_uop   (q_uop),
        .bstat   (bstat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
